/* rtl/ehms_pkg.sv */
// ----------------------------------------------------------------------------
// ehms_pkg
// Shared types, codes and constants of the EMA hysteresis mode selector.
// ----------------------------------------------------------------------------
package ehms_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 8;

    localparam int THRESH_W   = 16;
    localparam int RATIO_W    = 9;
    localparam int HOLD_W     = 8;
    localparam int WEIGHT_W   = 9;
    localparam int Q_FRAC     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int MODE_W     = 3;
    localparam int OUT_DATA_W = 8;
    localparam int NUM_FIELDS = 5;

    localparam logic [WEIGHT_W-1:0] Q_ONE = WEIGHT_W'(256);

    typedef enum logic [MODE_W-1:0] {
        MODE_SAFE       = 3'd0,
        MODE_RECOVERY   = 3'd1,
        MODE_AGGRESSIVE = 3'd2,
        MODE_PRECISE    = 3'd3,
        MODE_CRUISE     = 3'd4
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAFE_DISTANCE    = 3'd0,
        REG_RECOVERY_ERROR   = 3'd1,
        REG_FAST_RATIO       = 3'd2,
        REG_PRECISE_DISTANCE = 3'd3,
        REG_HOLD_COUNT       = 3'd4,
        REG_BLEND_WEIGHT     = 3'd5
    } cfg_idx_t;

    localparam logic [THRESH_W-1:0] RST_SAFE_DISTANCE    = THRESH_W'(128);
    localparam logic [THRESH_W-1:0] RST_RECOVERY_ERROR   = THRESH_W'(77);
    localparam logic [RATIO_W-1:0]  RST_FAST_RATIO       = RATIO_W'(205);
    localparam logic [THRESH_W-1:0] RST_PRECISE_DISTANCE = THRESH_W'(256);
    localparam logic [HOLD_W-1:0]   RST_HOLD_COUNT       = HOLD_W'(3);
    localparam logic [WEIGHT_W-1:0] RST_BLEND_WEIGHT     = WEIGHT_W'(77);

    typedef struct packed {
        logic [THRESH_W-1:0] safe_distance;
        logic [THRESH_W-1:0] recovery_error;
        logic [RATIO_W-1:0]  fast_ratio;
        logic [THRESH_W-1:0] precise_distance;
        logic [HOLD_W-1:0]   hold_count;
        logic [WEIGHT_W-1:0] blend_weight;
    } cfg_t;

endpackage

/* rtl/ema_hysteresis_mode_selector_unit.sv */
// ----------------------------------------------------------------------------
// ema_hysteresis_mode_selector_unit
// Smooths four measurements and selects a driving mode with hysteresis.
// ----------------------------------------------------------------------------
// One sample transfer can be taken every clock cycle while the result stream
// takes each result. The first stage holds the sample in the input register,
// the second runs the four moving-average multiplies (their results are the
// filter state, fed back for the next sample) and the third registers the
// ranked candidate through the hold counter onto the result stream.
// Each stage waits only when the one after it is full, so while a finished
// result waits on the output the input takes up to two more samples and then
// stalls until the result is taken.
// ----------------------------------------------------------------------------
module ema_hysteresis_mode_selector_unit
    import ehms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // speed_in, speed_limit, obstacle_dist, track_error, goal_range (lowest first)
    input  logic [((NUM_FIELDS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // active_mode in bits 2:0, zero above
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int IN_DATA_W = ((NUM_FIELDS * SAMPLE_BITS + 7) / 8) * 8;

    cfg_t                           cfg;
    logic                           ema_valid;
    logic                           mode_ready;
    logic [SAMPLE_BITS-1:0]         avg_speed;
    logic [SAMPLE_BITS-1:0]         avg_obstacle;
    logic [SAMPLE_BITS-1:0]         avg_error;
    logic [SAMPLE_BITS-1:0]         avg_goal;
    logic [SAMPLE_BITS+RATIO_W-1:0] ratio_prod;
    logic                           limit_nz;
    mode_t                          active_mode;

    ehms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ehms_ema_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_DATA_W   (IN_DATA_W)
    ) u_ema (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_data      (s_tdata),
        .out_valid    (ema_valid),
        .out_ready    (mode_ready),
        .avg_speed    (avg_speed),
        .avg_obstacle (avg_obstacle),
        .avg_error    (avg_error),
        .avg_goal     (avg_goal),
        .ratio_prod   (ratio_prod),
        .limit_nz     (limit_nz)
    );

    ehms_mode_stage #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_mode (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (ema_valid),
        .in_ready     (mode_ready),
        .avg_speed    (avg_speed),
        .avg_obstacle (avg_obstacle),
        .avg_error    (avg_error),
        .avg_goal     (avg_goal),
        .ratio_prod   (ratio_prod),
        .limit_nz     (limit_nz),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .active_mode  (active_mode)
    );

    assign m_tdata = OUT_DATA_W'(active_mode);

endmodule

/* rtl/ehms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ehms_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ehms_cfg_regs
    import ehms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_SAFE_DISTANCE:    cfg_next.safe_distance    = cfg_wdata[THRESH_W-1:0];
                REG_RECOVERY_ERROR:   cfg_next.recovery_error   = cfg_wdata[THRESH_W-1:0];
                REG_FAST_RATIO:       cfg_next.fast_ratio       = cfg_wdata[RATIO_W-1:0];
                REG_PRECISE_DISTANCE: cfg_next.precise_distance = cfg_wdata[THRESH_W-1:0];
                REG_HOLD_COUNT:       cfg_next.hold_count       = cfg_wdata[HOLD_W-1:0];
                REG_BLEND_WEIGHT:     cfg_next.blend_weight     = cfg_wdata[WEIGHT_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.safe_distance    <= RST_SAFE_DISTANCE;
            cfg_reg.recovery_error   <= RST_RECOVERY_ERROR;
            cfg_reg.fast_ratio       <= RST_FAST_RATIO;
            cfg_reg.precise_distance <= RST_PRECISE_DISTANCE;
            cfg_reg.hold_count       <= RST_HOLD_COUNT;
            cfg_reg.blend_weight     <= RST_BLEND_WEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/ehms_ema_stage.sv */
// ----------------------------------------------------------------------------
// ehms_ema_stage
// Input register, then the four moving averages and the speed limit product.
// ----------------------------------------------------------------------------
module ehms_ema_stage
    import ehms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_DATA_W   = ((NUM_FIELDS * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [IN_DATA_W-1:0]           in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [SAMPLE_BITS-1:0]         avg_speed,
    output logic [SAMPLE_BITS-1:0]         avg_obstacle,
    output logic [SAMPLE_BITS-1:0]         avg_error,
    output logic [SAMPLE_BITS-1:0]         avg_goal,
    output logic [SAMPLE_BITS+RATIO_W-1:0] ratio_prod,
    output logic                           limit_nz
);

    localparam int S      = SAMPLE_BITS;
    localparam int PROD_W = S + WEIGHT_W;
    localparam int SUM_W  = S + 2;
    localparam int RP_W   = S + RATIO_W;

    // Stage 0: raw input fields.
    logic         v0_reg, v0_next;
    logic [S-1:0] speed_reg, limit_reg, obst_reg, err_reg, goal_reg;

    // Stage 1: averages (also the filter state) and ratio product.
    logic            v1_reg, v1_next;
    logic            primed_reg, primed_next;
    logic [S-1:0]    avg_speed_reg, avg_speed_next;
    logic [S-1:0]    avg_obst_reg, avg_obst_next;
    logic [S-1:0]    avg_err_reg, avg_err_next;
    logic [S-1:0]    avg_goal_reg, avg_goal_next;
    logic [RP_W-1:0] ratio_prod_reg, ratio_prod_next;
    logic            limit_nz_reg, limit_nz_next;

    logic                s1_ready;
    logic                in_fire;
    logic                s1_load;
    logic [WEIGHT_W-1:0] weight;

    function automatic logic [S-1:0] blend(
        input logic [S-1:0]        avg,
        input logic [S-1:0]        x,
        input logic [WEIGHT_W-1:0] w
    );
        logic [PROD_W-1:0] pa;
        logic [PROD_W-1:0] pb;
        logic [SUM_W-1:0]  sum;
        pa  = PROD_W'(w) * PROD_W'(x);
        pb  = PROD_W'(Q_ONE - w) * PROD_W'(avg);
        sum = SUM_W'(pa >> Q_FRAC) + SUM_W'(pb >> Q_FRAC);
        return sum[S-1:0];
    endfunction

    assign s1_ready = !v1_reg || out_ready;
    assign in_ready = !v0_reg || s1_ready;
    assign in_fire  = in_valid && in_ready;
    assign s1_load  = v0_reg && s1_ready;

    assign weight = (cfg.blend_weight > Q_ONE) ? Q_ONE : cfg.blend_weight;

    always_comb
    begin
        v0_next = in_fire ? 1'b1 : (s1_ready ? 1'b0 : v0_reg);
        v1_next = s1_load ? 1'b1 : (out_ready ? 1'b0 : v1_reg);

        primed_next     = primed_reg;
        avg_speed_next  = avg_speed_reg;
        avg_obst_next   = avg_obst_reg;
        avg_err_next    = avg_err_reg;
        avg_goal_next   = avg_goal_reg;
        ratio_prod_next = ratio_prod_reg;
        limit_nz_next   = limit_nz_reg;

        if (s1_load)
        begin
            primed_next     = 1'b1;
            ratio_prod_next = RP_W'(cfg.fast_ratio) * RP_W'(limit_reg);
            limit_nz_next   = (limit_reg != '0);
            // The first item after reset seeds the averages directly.
            if (!primed_reg)
            begin
                avg_speed_next = speed_reg;
                avg_obst_next  = obst_reg;
                avg_err_next   = err_reg;
                avg_goal_next  = goal_reg;
            end
            else
            begin
                avg_speed_next = blend(avg_speed_reg, speed_reg, weight);
                avg_obst_next  = blend(avg_obst_reg, obst_reg, weight);
                avg_err_next   = blend(avg_err_reg, err_reg, weight);
                avg_goal_next  = blend(avg_goal_reg, goal_reg, weight);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            primed_reg    <= 1'b0;
            avg_speed_reg <= '0;
            avg_obst_reg  <= '0;
            avg_err_reg   <= '0;
            avg_goal_reg  <= '0;
        end
        else
        begin
            v0_reg        <= v0_next;
            v1_reg        <= v1_next;
            primed_reg    <= primed_next;
            avg_speed_reg <= avg_speed_next;
            avg_obst_reg  <= avg_obst_next;
            avg_err_reg   <= avg_err_next;
            avg_goal_reg  <= avg_goal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            speed_reg <= in_data[0*S +: S];
            limit_reg <= in_data[1*S +: S];
            obst_reg  <= in_data[2*S +: S];
            err_reg   <= in_data[3*S +: S];
            goal_reg  <= in_data[4*S +: S];
        end
        ratio_prod_reg <= ratio_prod_next;
        limit_nz_reg   <= limit_nz_next;
    end

    assign out_valid    = v1_reg;
    assign avg_speed    = avg_speed_reg;
    assign avg_obstacle = avg_obst_reg;
    assign avg_error    = avg_err_reg;
    assign avg_goal     = avg_goal_reg;
    assign ratio_prod   = ratio_prod_reg;
    assign limit_nz     = limit_nz_reg;

endmodule

/* rtl/ehms_mode_stage.sv */
// ----------------------------------------------------------------------------
// ehms_mode_stage
// Priority ranking of the averages and the hold counter that switches modes.
// ----------------------------------------------------------------------------
module ehms_mode_stage
    import ehms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [SAMPLE_BITS-1:0]         avg_speed,
    input  logic [SAMPLE_BITS-1:0]         avg_obstacle,
    input  logic [SAMPLE_BITS-1:0]         avg_error,
    input  logic [SAMPLE_BITS-1:0]         avg_goal,
    input  logic [SAMPLE_BITS+RATIO_W-1:0] ratio_prod,
    input  logic                           limit_nz,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mode_t                          active_mode
);

    localparam int S     = SAMPLE_BITS;
    localparam int RP_W  = S + RATIO_W;
    localparam int CMP_W = (S > THRESH_W) ? S : THRESH_W;
    localparam int CNT_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  valid_reg, valid_next;
    mode_t                 pending_reg, pending_next;
    mode_t                 current_reg, current_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    mode_t               cand;
    logic                load;
    logic                fast;
    logic [RP_W-1:0]     speed_scaled;
    logic [HOLD_W-1:0]   need;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Ratio test without a divider: avg_speed * 256 against fast_ratio * limit.
    assign speed_scaled = RP_W'({avg_speed, {Q_FRAC{1'b0}}});
    assign fast         = limit_nz && (speed_scaled > ratio_prod);
    assign need         = (cfg.hold_count == '0) ? HOLD_W'(1) : cfg.hold_count;

    always_comb
    begin
        if (CMP_W'(avg_obstacle) < CMP_W'(cfg.safe_distance))
            cand = MODE_SAFE;
        else if (CMP_W'(avg_error) > CMP_W'(cfg.recovery_error))
            cand = MODE_RECOVERY;
        else if (fast)
            cand = MODE_AGGRESSIVE;
        else if (CMP_W'(avg_goal) < CMP_W'(cfg.precise_distance))
            cand = MODE_PRECISE;
        else
            cand = MODE_CRUISE;
    end

    always_comb
    begin
        valid_next   = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
        pending_next = pending_reg;
        count_next   = count_reg;
        current_next = current_reg;
        if (load)
        begin
            pending_next = cand;
            if (cand == pending_reg)
                count_next = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
            else
                count_next = COUNT_BITS'(1);
            if (CNT_W'(count_next) >= CNT_W'(need))
                current_next = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= MODE_CRUISE;
            current_reg <= MODE_CRUISE;
            count_reg   <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
            current_reg <= current_next;
            count_reg   <= count_next;
        end
    end

    assign out_valid   = valid_reg;
    assign active_mode = current_reg;

endmodule

/* rtl/ehms_checker.sv */
// ----------------------------------------------------------------------------
// ehms_checker
// Port-level checks of the mode selector, bound to the top level.
// ----------------------------------------------------------------------------
module ehms_checker
    import ehms_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A result that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only the five mode codes ever leave the block.
    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[MODE_W-1:0] <= MODE_CRUISE))
        else $error("invalid mode code on output");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:MODE_W] == '0))
        else $error("padding bits of result not zero");

    // With the output register free, nothing in the pipe can block the input.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind ema_hysteresis_mode_selector_unit ehms_checker u_ehms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
